// ----- rtl/clss_pkg.sv -----
// Shared types, constants and helpers for the caseless line substring search.
// No dependencies; every other file in rtl/ refers to this package by scope.
package clss_pkg;

  localparam int MAX_PATTERN_DEF      = 32;
  localparam int LINE_NUMBER_BITS_DEF = 16;
  localparam int QUEUE_DEPTH          = 2;

  localparam int CFG_INDEX_BITS    = 8;
  localparam int CFG_DATA_BITS     = 64;
  localparam int PATTERN_LEN_BITS  = 6;
  localparam int START_LINE_BITS   = 16;
  localparam int NUM_PATTERN_WORDS = 4;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_0 = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_1 = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_2 = 8'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_3 = 8'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_LINE     = 8'd5;

  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
  localparam logic [7:0] ASCII_CASE    = 8'h20;

  // One classified text item as it travels from front to back
  typedef struct packed {
    logic [7:0] ch;      // folded to upper case
    logic       valid;   // real character
    logic       last;    // closes the line
    logic       fresh;   // starts a new search
  } item_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
      r = c - ASCII_CASE;
    end
    return r;
  endfunction

endpackage

// ----- rtl/clss_front.sv -----
// Front end: configuration registers, input acceptance and case folding.
// Also keeps the pattern aligned to window positions. Uses clss_pkg.
module clss_front #(
  parameter int MAX_PATTERN = clss_pkg::MAX_PATTERN_DEF,
  parameter int CW          = $clog2(MAX_PATTERN + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [clss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [clss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          text_byte,
  input  logic                                byte_valid,
  input  logic                                line_end,
  input  logic                                new_search,
  output logic                                q_push,
  output clss_pkg::item_t                     q_item,
  input  logic                                q_full,
  output logic [MAX_PATTERN-1:0][7:0]         aligned,
  output logic [MAX_PATTERN-1:0]              care,
  output logic [CW-1:0]                       len_eff,
  output logic [clss_pkg::START_LINE_BITS-1:0] start_line
);

  localparam int IW = $clog2(MAX_PATTERN);

  logic [clss_pkg::PATTERN_LEN_BITS-1:0]                        pattern_length;
  logic [clss_pkg::NUM_PATTERN_WORDS-1:0][clss_pkg::CFG_DATA_BITS-1:0] pattern_word;
  logic                                                         settle;
  logic                                                         cfg_write;

  logic [MAX_PATTERN-1:0][7:0] pat_chars;
  logic [MAX_PATTERN-1:0][7:0] aligned_next;
  logic [MAX_PATTERN-1:0]      care_next;
  logic [CW-1:0]               len_eff_next;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= clss_pkg::PATTERN_LEN_BITS'(1);
      pattern_word   <= '0;
      start_line     <= '0;
      settle         <= 1'b1;
    end else begin
      settle <= cfg_write;
      if (cfg_write) begin
        unique case (cfg_index)
          clss_pkg::REG_PATTERN_LENGTH:
            pattern_length <= cfg_data[clss_pkg::PATTERN_LEN_BITS-1:0];
          clss_pkg::REG_PATTERN_WORD_0: pattern_word[0] <= cfg_data;
          clss_pkg::REG_PATTERN_WORD_1: pattern_word[1] <= cfg_data;
          clss_pkg::REG_PATTERN_WORD_2: pattern_word[2] <= cfg_data;
          clss_pkg::REG_PATTERN_WORD_3: pattern_word[3] <= cfg_data;
          clss_pkg::REG_START_LINE:
            start_line <= cfg_data[clss_pkg::START_LINE_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // Pattern character i sits in word i/8, byte i%8
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pat_chars[i] = clss_pkg::fold_upper(pattern_word[i / 8][(i % 8) * 8 +: 8]);
    end
  end

  // Window position p (0 = newest) must hold pattern character len-1-p
  always_comb begin
    logic [CW-1:0] idx;
    if (pattern_length > clss_pkg::PATTERN_LEN_BITS'(MAX_PATTERN)) begin
      len_eff_next = CW'(MAX_PATTERN);
    end else begin
      len_eff_next = pattern_length[CW-1:0];
    end
    for (int p = 0; p < MAX_PATTERN; p++) begin
      idx             = len_eff_next - CW'(1) - CW'(p);
      care_next[p]    = CW'(p) < len_eff_next;
      aligned_next[p] = pat_chars[idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    aligned <= aligned_next;
    care    <= care_next;
    len_eff <= len_eff_next;
  end

  // Hold off input while a register write is offered and while settle is set after it, so the aligned copy catches up
  assign in_ready = !q_full && !cfg_valid && !settle;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_item.ch    = clss_pkg::fold_upper(text_byte);
    q_item.valid = byte_valid;
    q_item.last  = line_end;
    q_item.fresh = new_search;
  end

endmodule

// ----- rtl/clss_queue.sv -----
// Short queue of classified items between the front end and the match engine.
// Uses clss_pkg::item_t.
module clss_queue #(
  parameter int DEPTH = clss_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  clss_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output clss_pkg::item_t head_item
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  clss_pkg::item_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  assign full       = count == CNTW'(DEPTH);
  assign head_valid = count != '0;
  assign head_item  = entries[rd_ptr];

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> count != CNTW'(DEPTH))
    else $error("queue pushed while full");

endmodule

// ----- rtl/clss_back.sv -----
// Match engine: byte window, parallel compare, per-line hit flag and line counter,
// plus the result register. Uses clss_pkg::item_t.
module clss_back #(
  parameter int MAX_PATTERN      = clss_pkg::MAX_PATTERN_DEF,
  parameter int LINE_NUMBER_BITS = clss_pkg::LINE_NUMBER_BITS_DEF,
  parameter int CW               = $clog2(MAX_PATTERN + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 head_valid,
  input  clss_pkg::item_t                      head_item,
  output logic                                 pop,
  input  logic [MAX_PATTERN-1:0][7:0]          aligned,
  input  logic [MAX_PATTERN-1:0]               care,
  input  logic [CW-1:0]                        len_eff,
  input  logic [clss_pkg::START_LINE_BITS-1:0] start_line,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 line_hit,
  output logic [LINE_NUMBER_BITS-1:0]          line_number
);

  logic [MAX_PATTERN-1:0][7:0]  window;
  logic [MAX_PATTERN-1:0][7:0]  window_next;
  logic [CW-1:0]                bytes_in_line;
  logic [CW-1:0]                bytes_in_line_next;
  logic                         hit_in_line;
  logic                         hit_in_line_next;
  logic [LINE_NUMBER_BITS-1:0]  line_ctr;
  logic [LINE_NUMBER_BITS-1:0]  line_ctr_next;
  logic [LINE_NUMBER_BITS-1:0]  start_ext;
  logic [LINE_NUMBER_BITS-1:0]  line_cur;
  logic                         hit_cur;
  logic [LINE_NUMBER_BITS+clss_pkg::START_LINE_BITS-1:0] start_wide;

  assign start_wide = {{LINE_NUMBER_BITS{1'b0}}, start_line};
  assign start_ext  = start_wide[LINE_NUMBER_BITS-1:0];

  // Advance unless a line end would land on a result that is still waiting
  assign pop = head_valid && (!head_item.last || !out_valid || out_ready);

  always_comb begin
    logic [CW-1:0] cnt0;
    logic          hit0;
    logic          match;
    cnt0     = head_item.fresh ? '0 : bytes_in_line;
    hit0     = head_item.fresh ? 1'b0 : hit_in_line;
    line_cur = head_item.fresh ? start_ext : line_ctr;
    match    = 1'b0;

    window_next        = window;
    bytes_in_line_next = cnt0;
    hit_cur            = hit0;
    if (head_item.valid) begin
      window_next = {window[MAX_PATTERN-2:0], head_item.ch};
      if (cnt0 < CW'(MAX_PATTERN)) begin
        bytes_in_line_next = cnt0 + CW'(1);
      end
      match = (len_eff != '0) && (bytes_in_line_next >= len_eff);
      for (int p = 0; p < MAX_PATTERN; p++) begin
        if (care[p] && window_next[p] != aligned[p]) begin
          match = 1'b0;
        end
      end
      hit_cur = hit0 || match;
    end

    hit_in_line_next = hit_cur;
    line_ctr_next    = line_cur;
    if (head_item.last) begin
      bytes_in_line_next = '0;
      hit_in_line_next   = 1'b0;
      if (line_cur != {LINE_NUMBER_BITS{1'b1}}) begin
        line_ctr_next = line_cur + LINE_NUMBER_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_line <= '0;
      hit_in_line   <= 1'b0;
      line_ctr      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        bytes_in_line <= bytes_in_line_next;
        hit_in_line   <= hit_in_line_next;
        line_ctr      <= line_ctr_next;
      end
      if (pop && head_item.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      window <= window_next;
    end
    if (pop && head_item.last) begin
      line_hit    <= hit_cur;
      line_number <= line_cur;
    end
  end

  a_fresh_number: assert property (@(posedge clk) disable iff (rst)
    pop && head_item.fresh && head_item.last
      |=> out_valid && line_number == $past(start_ext))
    else $error("first line of a search not numbered from start_line");

  a_empty_no_hit: assert property (@(posedge clk) disable iff (rst)
    pop && head_item.last && !head_item.valid && (head_item.fresh || bytes_in_line == '0)
      |=> !line_hit)
    else $error("empty line reported as a hit");

  a_counter_up: assert property (@(posedge clk) disable iff (rst)
    pop && !head_item.fresh |=> line_ctr >= $past(line_ctr))
    else $error("line counter went backward within a search");

endmodule

// ----- rtl/caseless_line_substring_search_top.sv -----
// Top level of the caseless line substring search: front end, queue, match engine.
// Depends on clss_pkg, clss_front, clss_queue and clss_back.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in       | in_valid / in_ready   | text_byte, byte_valid, line_end, new_search
//  out      | out_valid / out_ready | line_hit, line_number
//
// One item per cycle sustained, unless a register write, a full queue or a stalled
// result holds the flow; the window shift and parallel compare in the match engine
// handle each item as it is popped. A line-end item's result passes through the queue and
// the result register before it reaches the outputs. in_ready drops while cfg_valid is
// high and while the settle flag that a register write or reset sets is high. Reset is synchronous.
// A stalled result holds the match engine only when the next line end arrives;
// the two-entry queue absorbs input meanwhile.
module caseless_line_substring_search_top #(
  parameter int MAX_PATTERN      = clss_pkg::MAX_PATTERN_DEF,
  parameter int LINE_NUMBER_BITS = clss_pkg::LINE_NUMBER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [clss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [clss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          text_byte,
  input  logic                                byte_valid,
  input  logic                                line_end,
  input  logic                                new_search,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                line_hit,
  output logic [LINE_NUMBER_BITS-1:0]         line_number
);

  localparam int CW = $clog2(MAX_PATTERN + 1);

  logic                                 q_push;
  clss_pkg::item_t                      q_item;
  logic                                 q_full;
  logic                                 q_pop;
  logic                                 head_valid;
  clss_pkg::item_t                      head_item;
  logic [MAX_PATTERN-1:0][7:0]          aligned;
  logic [MAX_PATTERN-1:0]               care;
  logic [CW-1:0]                        len_eff;
  logic [clss_pkg::START_LINE_BITS-1:0] start_line;

  clss_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .CW          (CW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .text_byte  (text_byte),
    .byte_valid (byte_valid),
    .line_end   (line_end),
    .new_search (new_search),
    .q_push     (q_push),
    .q_item     (q_item),
    .q_full     (q_full),
    .aligned    (aligned),
    .care       (care),
    .len_eff    (len_eff),
    .start_line (start_line)
  );

  clss_queue #(
    .DEPTH (clss_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  clss_back #(
    .MAX_PATTERN      (MAX_PATTERN),
    .LINE_NUMBER_BITS (LINE_NUMBER_BITS),
    .CW               (CW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (q_pop),
    .aligned     (aligned),
    .care        (care),
    .len_eff     (len_eff),
    .start_line  (start_line),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .line_hit    (line_hit),
    .line_number (line_number)
  );

endmodule

// ----- tb/tb_caseless_line_substring_search_top.sv -----
// Self-checking testbench for caseless_line_substring_search_top.
// Uses clss_pkg for register indexes and ASCII constants; a directed table runs
// first, then random lines under changing patterns, checked by a local predictor.
module tb_caseless_line_substring_search_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN          = clss_pkg::MAX_PATTERN_DEF;
  localparam int RANDOM_BEATS = 850;
  localparam int QUIET_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_PCT     = 12;
  localparam logic [7:0] BORDER [10] = '{8'h00, 8'h40, 8'h41, 8'h5A, 8'h5B,
                                         8'h60, 8'h61, 8'h7A, 8'h7B, 8'hFF};

  typedef struct packed {
    logic        hit;
    logic [15:0] num;
  } line_result_t;

  // one row of stimulus: a register write or a text beat
  typedef struct packed {
    bit          wr;
    logic [7:0]  idx;
    logic [63:0] data;
    logic [7:0]  ch;
    bit          bv;
    bit          le;
    bit          ns;
    bit          typed;
    logic        hit;
    logic [15:0] num;
  } step_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  text_byte;
  logic        byte_valid;
  logic        line_end;
  logic        new_search;
  logic        out_valid;
  logic        out_ready;
  logic        line_hit;
  logic [15:0] line_number;

  caseless_line_substring_search_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .text_byte(text_byte),
    .byte_valid(byte_valid), .line_end(line_end), .new_search(new_search),
    .out_valid(out_valid), .out_ready(out_ready), .line_hit(line_hit),
    .line_number(line_number)
  );

  // predictor state and its copy of the registers
  logic [7:0]   win [WIN];
  int           line_fill;
  bit           line_has_hit;
  logic [15:0]  line_no;
  logic [5:0]   pat_len;
  logic [63:0]  pat_word [clss_pkg::NUM_PATTERN_WORDS];
  logic [15:0]  first_line;

  line_result_t pending_lines [$];
  line_result_t want;
  step_t        plan [$];
  int           bad_lines;
  int           useful_beats;
  int           cycles;
  bit           calm;
  logic [7:0]   phase_pat [WIN];
  int           phase_eff;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] to_caps(input logic [7:0] c);
    return (c >= clss_pkg::ASCII_LOWER_A && c <= clss_pkg::ASCII_LOWER_Z) ?
           c - clss_pkg::ASCII_CASE : c;
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (to_caps(c) >= 8'h41 && to_caps(c) <= 8'h5A && $urandom_range(0, 1) == 1)
      return c ^ clss_pkg::ASCII_CASE;
    return c;
  endfunction

  // advance the predictor by one beat; returns 1 when the beat closes a line
  function automatic bit search_step(input logic [7:0] ch, input bit bv, input bit le,
                                     input bit ns, output line_result_t r);
    int  eff;
    bit  same;
    if (ns) begin
      line_no = first_line;
      line_fill = 0;
      line_has_hit = 1'b0;
    end
    if (bv) begin
      for (int k = WIN - 1; k > 0; k--) win[k] = win[k-1];
      win[0] = to_caps(ch);
      if (line_fill < WIN) line_fill++;
      eff = (pat_len > WIN) ? WIN : pat_len;
      if (eff != 0 && line_fill >= eff) begin
        same = 1'b1;
        for (int i = 0; i < eff; i++) begin
          if (win[eff-1-i] != to_caps(pat_word[i/8][8*(i%8) +: 8])) same = 1'b0;
        end
        if (same) line_has_hit = 1'b1;
      end
    end
    r.hit = line_has_hit;
    r.num = line_no;
    if (!le) return 1'b0;
    line_fill = 0;
    line_has_hit = 1'b0;
    if (line_no != 16'hFFFF) line_no++;
    return 1'b1;
  endfunction

  function automatic step_t beat(input logic [7:0] ch, input bit bv, input bit le,
                                 input bit ns);
    step_t s;
    s = '0;
    s.ch = ch;
    s.bv = bv;
    s.le = le;
    s.ns = ns;
    return s;
  endfunction

  function automatic step_t beat_is(input logic [7:0] ch, input bit bv, input bit le,
                                    input bit ns, input logic hit, input logic [15:0] num);
    step_t s;
    s = beat(ch, bv, le, ns);
    s.typed = 1'b1;
    s.hit = hit;
    s.num = num;
    return s;
  endfunction

  function automatic step_t reg_wr(input logic [7:0] idx, input logic [63:0] data);
    step_t s;
    s = '0;
    s.wr = 1'b1;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  function automatic logic [7:0] pick_pattern_char();
    case ($urandom_range(0, 9))
      0, 1:    return BORDER[$urandom_range(0, 9)];
      2:       return 8'($urandom_range(0, 255));
      3, 4:    return flip_case(8'h41 + 8'($urandom_range(0, 25)));
      default: return flip_case(8'h41 + 8'($urandom_range(0, 5)));
    endcase
  endfunction

  // filler leans on pattern characters so that near misses are common
  function automatic logic [7:0] filler_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return BORDER[$urandom_range(0, 9)];
      3, 4:    return 8'($urandom_range(0, 255));
      default: begin
        if (phase_eff > 0) return flip_case(phase_pat[$urandom_range(0, phase_eff - 1)]);
        return flip_case(8'h41 + 8'($urandom_range(0, 25)));
      end
    endcase
  endfunction

  function automatic int pick_gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
  endfunction

  // drop valid, let every expected line drain, then give the pipe time to empty
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_lines.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] data);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      clss_pkg::REG_PATTERN_LENGTH: pat_len = data[clss_pkg::PATTERN_LEN_BITS-1:0];
      clss_pkg::REG_PATTERN_WORD_0: pat_word[0] = data;
      clss_pkg::REG_PATTERN_WORD_1: pat_word[1] = data;
      clss_pkg::REG_PATTERN_WORD_2: pat_word[2] = data;
      clss_pkg::REG_PATTERN_WORD_3: pat_word[3] = data;
      clss_pkg::REG_START_LINE:     first_line = data[clss_pkg::START_LINE_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_beat(input step_t s);
    line_result_t r;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    text_byte  <= s.ch;
    byte_valid <= s.bv;
    line_end   <= s.le;
    new_search <= s.ns;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (search_step(s.ch, s.bv, s.le, s.ns, r)) begin
      if (s.typed) begin
        r.hit = s.hit;
        r.num = s.num;
      end
      pending_lines.push_back(r);
    end
    if (s.bv || s.le || s.ns) useful_beats++;
    @(negedge clk);
  endtask

  task automatic run_phase(input int p);
    logic [63:0] w;
    logic [5:0]  plen;
    logic [15:0] sl;
    logic [7:0]  line_q [$];
    int          sel, budget, n_fill, cut, split_rest, carry;
    bit          fresh, tail_blank, drop;
    for (int i = 0; i < WIN; i++) phase_pat[i] = pick_pattern_char();
    sel = (p < 7) ? p : $urandom_range(0, 9);
    case (sel)
      0:       plen = 6'd1;
      1:       plen = 6'd32;
      2:       plen = 6'd0;
      3:       plen = 6'd63;
      4:       plen = 6'($urandom_range(33, 62));
      5:       plen = 6'($urandom_range(9, 31));
      default: plen = 6'($urandom_range(2, 8));
    endcase
    case ($urandom_range(0, 4))
      0:       sl = 16'h0000;
      1:       sl = 16'hFFFF;
      2:       sl = 16'hFFFF - 16'($urandom_range(0, 6));
      default: sl = 16'($urandom_range(0, 65535));
    endcase
    phase_eff = (plen > WIN) ? WIN : plen;

    w = {$urandom, $urandom};
    w[clss_pkg::PATTERN_LEN_BITS-1:0] = plen;
    write_reg(clss_pkg::REG_PATTERN_LENGTH, w);
    for (int j = 0; j < clss_pkg::NUM_PATTERN_WORDS; j++) begin
      for (int b = 0; b < 8; b++) w[8*b +: 8] = phase_pat[8*j + b];
      write_reg(clss_pkg::REG_PATTERN_WORD_0 + 8'(j), w);
    end
    w = {$urandom, $urandom};
    w[clss_pkg::START_LINE_BITS-1:0] = sl;
    write_reg(clss_pkg::REG_START_LINE, w);
    if ($urandom_range(0, 3) == 0) write_reg(8'($urandom_range(6, 255)), {$urandom, $urandom});

    budget = $urandom_range(40, 120);
    fresh = 1'b1;
    split_rest = 0;
    while (budget > 0 && useful_beats < RANDOM_BEATS + 30) begin
      line_q.delete();
      // finish a pattern that the previous line cut off
      for (int k = phase_eff - split_rest; k < phase_eff; k++) line_q.push_back(flip_case(phase_pat[k]));
      split_rest = 0;
      n_fill = pick_gap_len();
      repeat (n_fill) line_q.push_back(filler_char());
      if (phase_eff > 0 && $urandom_range(0, 99) < 55) begin
        cut = ($urandom_range(0, 9) == 0) ? phase_eff - 1 : phase_eff;
        for (int k = 0; k < cut; k++) line_q.push_back(flip_case(phase_pat[k]));
      end
      n_fill = pick_gap_len();
      repeat (n_fill) line_q.push_back(filler_char());
      if (phase_eff >= 2 && $urandom_range(0, 99) < 12) begin
        split_rest = $urandom_range(1, phase_eff - 1);
        carry = phase_eff - split_rest;
        for (int k = 0; k < carry; k++) line_q.push_back(flip_case(phase_pat[k]));
      end

      if (line_q.size() == 0) begin
        send_beat(beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, fresh));
      end else begin
        tail_blank = ($urandom_range(0, 6) == 0);
        foreach (line_q[i]) begin
          if ($urandom_range(0, 19) == 0)
            send_beat(beat(8'($urandom_range(0, 255)), 1'b0, 1'b0,
                           $urandom_range(0, 9) == 0));
          drop = !fresh && $urandom_range(0, 59) == 0;
          send_beat(beat(line_q[i], 1'b1, !tail_blank && i == line_q.size() - 1, fresh || drop));
          fresh = 1'b0;
        end
        if (tail_blank) send_beat(beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0));
      end
      fresh = 1'b0;
      budget -= line_q.size() + 1;
    end
  endtask

  // result side: stall at random except in the calm stretch
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_lines.size() == 0) begin
        bad_lines++;
        if (bad_lines <= 10)
          $display("unexpected line result: hit=%0b line=%0d", line_hit, line_number);
      end else begin
        want = pending_lines.pop_front();
        if (line_hit !== want.hit || line_number !== want.num) begin
          bad_lines++;
          if (bad_lines <= 10)
            $display("line result mismatch: hit exp %0b got %0b, line exp %0d got %0d",
                     want.hit, line_hit, want.num, line_number);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_caseless_line_substring_search_top: FAIL");
      $finish;
    end
  end

  initial begin
    int target;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    text_byte = '0;
    byte_valid = 1'b0;
    line_end = 1'b0;
    new_search = 1'b0;
    out_ready = 1'b0;
    calm = 1'b0;
    cycles = 0;
    bad_lines = 0;
    useful_beats = 0;
    foreach (win[k]) win[k] = '0;
    line_fill = 0;
    line_has_hit = 1'b0;
    line_no = '0;
    pat_len = 6'd1;
    foreach (pat_word[k]) pat_word[k] = '0;
    first_line = '0;

    // after reset the pattern is one NUL character
    plan.push_back(beat_is(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
    plan.push_back(beat_is(8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 16'd1));
    plan.push_back(beat_is(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 16'd2));
    plan.push_back(beat(8'h00, 1'b0, 1'b0, 1'b0));
    plan.push_back(reg_wr(clss_pkg::REG_START_LINE, 64'hABCD_0000_0000_FFFE));
    plan.push_back(reg_wr(clss_pkg::REG_PATTERN_LENGTH, 64'h0000_0000_0000_00C3));
    plan.push_back(reg_wr(clss_pkg::REG_PATTERN_WORD_0, 64'h5A5A_5A5A_5A63_4261));
    plan.push_back(beat(8'h78, 1'b1, 1'b0, 1'b1));
    plan.push_back(beat(8'h41, 1'b1, 1'b0, 1'b0));
    plan.push_back(beat(8'h62, 1'b1, 1'b0, 1'b0));
    plan.push_back(beat_is(8'h43, 1'b1, 1'b1, 1'b0, 1'b1, 16'hFFFE));
    // line numbers hold at the top
    plan.push_back(beat(8'h61, 1'b1, 1'b0, 1'b0));
    plan.push_back(beat(8'h62, 1'b1, 1'b0, 1'b0));
    plan.push_back(beat_is(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 16'hFFFF));
    // a match spanning a line end must not count
    plan.push_back(beat(8'h41, 1'b1, 1'b0, 1'b0));
    plan.push_back(beat_is(8'h42, 1'b1, 1'b1, 1'b0, 1'b0, 16'hFFFF));
    plan.push_back(beat_is(8'h63, 1'b1, 1'b1, 1'b0, 1'b0, 16'hFFFF));
    // new search drops the line in progress
    plan.push_back(beat(8'h61, 1'b1, 1'b0, 1'b0));
    plan.push_back(beat(8'h62, 1'b1, 1'b0, 1'b0));
    plan.push_back(beat_is(8'h63, 1'b1, 1'b1, 1'b1, 1'b0, 16'hFFFE));
    // zero length never matches
    plan.push_back(reg_wr(clss_pkg::REG_PATTERN_LENGTH, 64'h0000_0000_0000_0040));
    plan.push_back(beat_is(8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 16'hFFFF));
    // characters next to the letter ranges are not folded
    plan.push_back(reg_wr(clss_pkg::REG_START_LINE, 64'h0));
    plan.push_back(reg_wr(clss_pkg::REG_PATTERN_LENGTH, 64'h2));
    plan.push_back(reg_wr(clss_pkg::REG_PATTERN_WORD_0, 64'h0000_0000_0000_5B40));
    plan.push_back(beat(8'h60, 1'b1, 1'b0, 1'b1));
    plan.push_back(beat(8'h7B, 1'b1, 1'b1, 1'b0));
    plan.push_back(beat(8'h40, 1'b1, 1'b0, 1'b0));
    plan.push_back(beat(8'h5B, 1'b1, 1'b1, 1'b0));
    plan.push_back(beat(8'h7A, 1'b1, 1'b0, 1'b0));
    plan.push_back(beat(8'h5A, 1'b1, 1'b1, 1'b0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].wr) write_reg(plan[k].idx, plan[k].data);
      else send_beat(plan[k]);
    end

    target = useful_beats + RANDOM_BEATS;
    for (int p = 0; useful_beats < target; p++) begin
      calm = (p == 2 || p == 3);
      run_phase(p);
    end
    calm = 1'b0;

    wait_quiet();
    repeat (10) @(negedge clk);
    if (bad_lines == 0) begin
      $display("tb_caseless_line_substring_search_top: PASS");
    end else begin
      $display("tb_caseless_line_substring_search_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/clss_pkg.sv
rtl/clss_front.sv
rtl/clss_queue.sv
rtl/clss_back.sv
rtl/caseless_line_substring_search_top.sv
tb/tb_caseless_line_substring_search_top.sv
